@@ hw/rtl/dissemination_barrier_node_assert.svh @@
// ----------------------------------------------------------------------------
// Dissemination barrier node assertion macros
// Clocked, reset-qualified wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef DISSEMINATION_BARRIER_NODE_ASSERT_SVH
`define DISSEMINATION_BARRIER_NODE_ASSERT_SVH

// Same-cycle implication check, disabled while reset is asserted.
`define DBN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, disabled while reset is asserted.
`define DBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dbn_pkg.sv @@
// ----------------------------------------------------------------------------
// Dissemination barrier node package
// Shared widths, codes and transaction types.
// ----------------------------------------------------------------------------
package dbn_pkg;

    localparam int ID_W            = 6;
    localparam int CNT_W           = 7;
    localparam int ROUND_W         = 3;
    localparam int DIV_CNT_W       = $clog2(ID_W);
    localparam int CFG_IDX_W       = 1;
    localparam int MAX_NODES       = 64;
    localparam int DEF_MAX_ROUNDS  = 6;
    localparam int DEF_QUEUE_DEPTH = 2;

    typedef enum logic {
        ACT_ARRIVE  = 1'b0,
        ACT_MESSAGE = 1'b1
    } action_t;

    typedef enum logic {
        KIND_SEND = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID    = 1'b0,
        REG_NODE_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_FLAG   = 1'b1
    } cmd_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CASC
    } back_state_t;

    typedef struct packed {
        action_t              action;
        logic [ROUND_W-1:0]   msg_round;
        logic                 msg_sense;
    } in_item_t;

    typedef struct packed {
        kind_t                kind;
        logic [ID_W-1:0]      dest_node;
        logic [ROUND_W-1:0]   send_round;
        logic                 send_sense;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [ROUND_W-1:0]   round;
        logic                 sense;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]      node_id;
        logic [CNT_W-1:0]     count;
    } node_cfg_t;

endpackage

@@ hw/rtl/dbn_fifo.sv @@
// ----------------------------------------------------------------------------
// Dissemination barrier node small queue
// Register-based first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module dbn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/dbn_front.sv @@
// ----------------------------------------------------------------------------
// Dissemination barrier node front end
// Accept input transactions, classify them and queue commands for the back end.
// ----------------------------------------------------------------------------
module dbn_front
    import dbn_pkg::*;
#(
    parameter int MAX_ROUNDS  = DEF_MAX_ROUNDS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic keep;
    cmd_t cmd_in;
    logic cmd_empty;

    // Drop messages tagged with a round at or above MAX_ROUNDS, which this node never runs.
    always_comb
    begin
        keep         = 1'b1;
        cmd_in.op    = CMD_ARRIVE;
        cmd_in.round = item.msg_round;
        cmd_in.sense = item.msg_sense;
        unique case (item.action)
            ACT_ARRIVE:
            begin
                cmd_in.op = CMD_ARRIVE;
            end
            ACT_MESSAGE:
            begin
                cmd_in.op = CMD_FLAG;
                keep      = (int'(item.msg_round) < MAX_ROUNDS);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    dbn_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .full  (full),
        .wdata (cmd_in),
        .pop   (cmd_ready),
        .empty (cmd_empty),
        .rdata (cmd)
    );

    assign cmd_valid = !cmd_empty;

endmodule

@@ hw/rtl/dbn_back.sv @@
// ----------------------------------------------------------------------------
// Dissemination barrier node back end
// Run rounds, record peer flags, compute partners and queue results.
// ----------------------------------------------------------------------------
module dbn_back
    import dbn_pkg::*;
#(
    parameter int MAX_ROUNDS  = DEF_MAX_ROUNDS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CRW         = $clog2(MAX_ROUNDS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  node_cfg_t      cfg,
    input  logic [CRW-1:0] rounds,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  cmd_t           cmd,
    output logic           empty,
    input  logic           pop,
    output out_item_t      result
);

    back_state_t            state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic                   sense_reg, sense_next;
    logic                   parity_reg, parity_next;
    logic [CRW-1:0]         cur_reg, cur_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [MAX_ROUNDS-1:0]  flags_reg [2];
    logic [MAX_ROUNDS-1:0]  flags_next [2];
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [ID_W-1:0]        p_reg, p_next;

    logic [MAX_ROUNDS-1:0]  msg_flags;
    logic                   cur_flag;
    logic                   cur_flag_msg;
    logic [CNT_W-1:0]       p_dbl;
    logic [ID_W-1:0]        p_dbl_mod;
    logic [CNT_W-1:0]       div_shift;
    logic [CNT_W-1:0]       dest_sum;
    logic [ID_W-1:0]        dest;
    logic                   out_push;
    logic                   out_full;
    out_item_t              out_item;

    // Datapath: partner = (base + 2^k mod n) mod n, with base = node_id mod n.
    always_comb
    begin
        p_dbl     = {p_reg, 1'b0};
        p_dbl_mod = (p_dbl >= cfg.count) ? ID_W'(p_dbl - cfg.count) : ID_W'(p_dbl);
        div_shift = {rem_reg[ID_W-1:0], cfg.node_id[div_cnt_reg]};
        dest_sum  = {1'b0, rem_reg[ID_W-1:0]} + {1'b0, p_reg};
        dest      = (dest_sum >= cfg.count) ? ID_W'(dest_sum - cfg.count) : ID_W'(dest_sum);
    end

    // Flag lookups; the message view includes the flag being written now.
    always_comb
    begin
        msg_flags    = flags_reg[parity_reg];
        cur_flag     = 1'b0;
        cur_flag_msg = 1'b0;
        for (int i = 0; i < MAX_ROUNDS; i++)
        begin
            if (int'(cmd.round) == i)
            begin
                msg_flags[i] = cmd.sense;
            end
        end
        for (int i = 0; i < MAX_ROUNDS; i++)
        begin
            if (int'(cur_reg) == i)
            begin
                cur_flag     = flags_reg[parity_reg][i];
                cur_flag_msg = msg_flags[i];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        sense_next   = sense_reg;
        parity_next  = parity_reg;
        cur_next     = cur_reg;
        div_cnt_next = div_cnt_reg;
        flags_next   = flags_reg;
        rem_next     = rem_reg;
        p_next       = p_reg;
        cmd_ready    = (state_reg == ST_IDLE);
        out_push     = 1'b0;
        out_item     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        CMD_ARRIVE:
                        begin
                            if (!busy_reg)
                            begin
                                busy_next    = 1'b1;
                                cur_next     = '0;
                                rem_next     = '0;
                                div_cnt_next = DIV_CNT_W'(ID_W - 1);
                                state_next   = ST_DIV;
                            end
                        end
                        CMD_FLAG:
                        begin
                            flags_next[parity_reg] = msg_flags;
                            if (busy_reg && (int'(cur_reg) < MAX_ROUNDS) &&
                                (cur_flag_msg == sense_reg))
                            begin
                                cur_next   = cur_reg + 1'b1;
                                p_next     = p_dbl_mod;
                                state_next = ST_CASC;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                // One remainder bit per cycle, most significant first.
                rem_next = (div_shift >= cfg.count) ? div_shift - cfg.count : div_shift;
                if (div_cnt_reg == '0)
                begin
                    p_next     = (cfg.count == CNT_W'(1)) ? '0 : ID_W'(1);
                    state_next = ST_CASC;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end

            ST_CASC:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if (cur_reg >= rounds)
                    begin
                        out_item.kind = KIND_DONE;
                        out_item.last = 1'b1;
                        parity_next   = !parity_reg;
                        if (parity_reg)
                        begin
                            sense_next = !sense_reg;
                        end
                        busy_next  = 1'b0;
                        cur_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_item.kind       = KIND_SEND;
                        out_item.dest_node  = dest;
                        out_item.send_round = ROUND_W'(cur_reg);
                        out_item.send_sense = sense_reg;
                        out_item.last       = (cur_flag != sense_reg);
                        if (cur_flag == sense_reg)
                        begin
                            cur_next = cur_reg + 1'b1;
                            p_next   = p_dbl_mod;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            sense_reg   <= 1'b1;
            parity_reg  <= 1'b0;
            cur_reg     <= '0;
            div_cnt_reg <= '0;
            flags_reg   <= '{default: '0};
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            sense_reg   <= sense_next;
            parity_reg  <= parity_next;
            cur_reg     <= cur_next;
            div_cnt_reg <= div_cnt_next;
            flags_reg   <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        p_reg   <= p_next;
    end

    dbn_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .wdata (out_item),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule

@@ hw/rtl/dissemination_barrier_node.sv @@
// ----------------------------------------------------------------------------
// Dissemination barrier node
// One participant of a sense-reversing dissemination barrier with two parity
// banks: sends its sense to partners round by round and reports completion.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ----------------------------------------
//  input     push / full           item   : action, msg_round, msg_sense
//  result    pop / empty           result : kind, dest_node, send_round,
//                                           send_sense, last
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An input transaction waits in the front queue until the back end is idle
//  and decodes it. A local arrival then runs the serial remainder unit
//  (node_id mod count), after which the round sequencer writes one result
//  per cycle while the result queue is not full. A peer message records its
//  flag, and starts the round sequencer when it unblocks the current round.
//  Reset clears the flags, sets the sense to one and the parity to bank zero;
//  the configuration resets to node_id 0 and node_count 1.
//  A full result queue stalls the round sequencer; the command queue keeps
//  taking input transactions until it fills.
// ----------------------------------------------------------------------------
module dissemination_barrier_node
    import dbn_pkg::*;
#(
    parameter int MAX_ROUNDS  = DEF_MAX_ROUNDS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    localparam int CRW = $clog2(MAX_ROUNDS + 1);

    logic [ID_W-1:0]  node_id_reg;
    logic [CNT_W-1:0] node_count_reg;
    node_cfg_t        cfg;
    logic [CRW-1:0]   rounds;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= '0;
            node_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NODE_ID:
                begin
                    node_id_reg <= cfg_data[ID_W-1:0];
                end
                REG_NODE_COUNT:
                begin
                    node_count_reg <= cfg_data;
                end
                default:
                begin
                    node_id_reg <= node_id_reg;
                end
            endcase
        end
    end

    // Effective count: zero counts as one, saturate at the node limit.
    // Rounds: smallest r with 2^r >= count, capped at MAX_ROUNDS.
    always_comb
    begin
        int r;
        r           = 0;
        cfg.node_id = node_id_reg;
        cfg.count   = node_count_reg;
        if (node_count_reg == '0)
        begin
            cfg.count = CNT_W'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            cfg.count = CNT_W'(MAX_NODES);
        end
        for (int i = 0; i < CNT_W; i++)
        begin
            if ((CNT_W'(1) << i) < cfg.count)
            begin
                r = i + 1;
            end
        end
        if (r > MAX_ROUNDS)
        begin
            r = MAX_ROUNDS;
        end
        rounds = CRW'(r);
    end

    // Front: accept and classify input transactions.
    dbn_front #(
        .MAX_ROUNDS  (MAX_ROUNDS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: hold barrier state, advance rounds and queue results.
    dbn_back #(
        .MAX_ROUNDS  (MAX_ROUNDS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CRW         (CRW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rounds    (rounds),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

@@ hw/rtl/dbn_checker.sv @@
// ----------------------------------------------------------------------------
// Dissemination barrier node checker
// Port-level assertions on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "dissemination_barrier_node_assert.svh"

module dbn_checker
    import dbn_pkg::*;
#(
    parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
) (
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    `DBN_ASSERT_NOW(a_done_is_last,
        !empty && result.kind == KIND_DONE,
        result.last,
        "completion not marked last")
    `DBN_ASSERT_NOW(a_done_zero_fields,
        !empty && result.kind == KIND_DONE,
        result.dest_node == '0 && result.send_round == '0 && result.send_sense == 1'b0,
        "completion carries nonzero fields")
    `DBN_ASSERT_NOW(a_send_round_range,
        !empty && result.kind == KIND_SEND,
        int'(result.send_round) < MAX_ROUNDS,
        "send round out of range")
    `DBN_ASSERT_NEXT(a_result_holds,
        !empty && !pop,
        !empty && $stable(result),
        "waiting result changed")

endmodule

bind dissemination_barrier_node dbn_checker #(
    .MAX_ROUNDS (MAX_ROUNDS)
) u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
